>>> hdl/valve_sequencer_master_booster_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the valve sequencer
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef VALVE_SEQUENCER_MASTER_BOOSTER_CORE_MACROS_SVH
`define VALVE_SEQUENCER_MASTER_BOOSTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define VSMB_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define VSMB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/vsmb_pkg.sv
// ----------------------------------------------------------------------------
// Valve sequencer package
// Shared constants, codes, item and result types for the valve sequencer.
// ----------------------------------------------------------------------------
package vsmb_pkg;

   localparam int VALVES      = 8;
   localparam int VALVE_W     = 3;
   localparam int MASK_W      = 8;
   localparam int ELAPSED_W   = 17;
   localparam int SECONDS_W   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_PRESENT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOSTER_PRESENT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALVE_PRESENT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOSTER_SECONDS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_UP_SECONDS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_DOWN_SECONDS = 3'd5;

   localparam logic [SECONDS_W-1:0] RUN_UP_SECONDS_RESET   = 16'd2;
   localparam logic [SECONDS_W-1:0] RUN_DOWN_SECONDS_RESET = 16'd2;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RUN_UP   = 3'd1,
      PH_BOOST    = 3'd2,
      PH_RUN      = 3'd3,
      PH_RUN_DOWN = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_VALVE   = 2'd1,
      KIND_MASTER  = 2'd2,
      KIND_BOOSTER = 2'd3
   } kind_type;

   // Front-end classification of an accepted input
   typedef enum logic [1:0] {
      CLS_TICK    = 2'd0,
      CLS_COMMAND = 2'd1,
      CLS_SKIP    = 2'd2
   } cls_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PHASE,
      ST_DRAIN_RD,
      ST_DRAIN_EX,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_ST
   } step_type;

   typedef struct packed {
      cls_type              cls;
      logic [VALVE_W-1:0]   valve_index;
      logic                 command_on;
   } item_type;

   typedef struct packed {
      logic [VALVE_W-1:0]   valve_index;
      logic                 command_on;
   } pend_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALVE_W-1:0]   relay_index;
      logic                 relay_on;
   } res_type;

   typedef struct packed {
      logic                 master_present;
      logic                 booster_present;
      logic [MASK_W-1:0]    valve_present;
      logic [SECONDS_W-1:0] booster_seconds;
      logic [SECONDS_W-1:0] run_up_seconds;
      logic [SECONDS_W-1:0] run_down_seconds;
   } cfg_type;

   function automatic logic valve_exists(input logic [VALVE_W-1:0] idx,
                                         input logic [MASK_W-1:0]  present);
      return (int'(idx) < VALVES) && present[idx];
   endfunction

endpackage

>>> hdl/valve_sequencer_master_booster_core.sv
// ----------------------------------------------------------------------------
// Valve sequencer with master and booster relays
// Top level: configuration registers, input front end and step engine.
// ----------------------------------------------------------------------------
// Each input is a one-second tick or an open/close command for one valve.
// Commands for valves that are present go into a pending queue of
// QUEUE_DEPTH entries; a full queue drops the command and flags it in the
// status result. Every input runs the phase machine (idle, run-up, boost,
// run, run-down) and produces zero or more relay and valve results followed
// by one status result with rsp_last set. All results of an input carry the
// phase and open-valve mask as they stand after that input. The front end
// takes inputs into a two-entry queue while the engine works, so req_ready
// stays high until two inputs are waiting. The engine handles one input at a
// time and reads the pending queue one entry per cycle during the scan. A
// step takes the input, scans the pending queue, applies the phase checks,
// in boost or run drains the queue and then closes the drain, and at last
// emits each relay and valve result and the status. Each input is registered
// in the front-end queue before its step starts. Write configuration only
// while no input is in flight.
// ----------------------------------------------------------------------------
module valve_sequencer_master_booster_core
   import vsmb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [VALVE_W-1:0]     req_valve_index,
   input  logic                   req_command_on,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [VALVE_W-1:0]     rsp_relay_index,
   output logic                   rsp_relay_on,
   output logic [2:0]             rsp_phase,
   output logic [MASK_W-1:0]      rsp_open_mask,
   output logic                   rsp_dropped,
   output logic                   rsp_last,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid;
   logic     item_ready;
   item_type item;

   // Configuration writes always complete in one transfer
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MASTER_PRESENT:   cfg_in.master_present   = csr_data[0];
            CSR_BOOSTER_PRESENT:  cfg_in.booster_present  = csr_data[0];
            CSR_VALVE_PRESENT:    cfg_in.valve_present    = csr_data[MASK_W-1:0];
            CSR_BOOSTER_SECONDS:  cfg_in.booster_seconds  = csr_data[SECONDS_W-1:0];
            CSR_RUN_UP_SECONDS:   cfg_in.run_up_seconds   = csr_data[SECONDS_W-1:0];
            CSR_RUN_DOWN_SECONDS: cfg_in.run_down_seconds = csr_data[SECONDS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_present   <= 1'b0;
         cfg_ff.booster_present  <= 1'b0;
         cfg_ff.valve_present    <= '0;
         cfg_ff.booster_seconds  <= '0;
         cfg_ff.run_up_seconds   <= RUN_UP_SECONDS_RESET;
         cfg_ff.run_down_seconds <= RUN_DOWN_SECONDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept and classify, hold up to two inputs
   vsmb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .valve_present   (cfg_ff.valve_present),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_valve_index (req_valve_index),
      .req_command_on  (req_command_on),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   // Step engine: phase machine, pending queue, result stream
   vsmb_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_relay_index (rsp_relay_index),
      .rsp_relay_on    (rsp_relay_on),
      .rsp_phase       (rsp_phase),
      .rsp_open_mask   (rsp_open_mask),
      .rsp_dropped     (rsp_dropped),
      .rsp_last        (rsp_last)
   );

endmodule

>>> hdl/vsmb_front.sv
// ----------------------------------------------------------------------------
// Valve sequencer front end
// Accepts inputs, classifies them as tick, queued command or skipped command,
// and holds them in a two-entry queue for the step engine.
// ----------------------------------------------------------------------------
module vsmb_front
   import vsmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [MASK_W-1:0]  valve_present,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [VALVE_W-1:0] req_valve_index,
   input  logic               req_command_on,
   output logic               item_valid,
   input  logic               item_ready,
   output item_type           item
);

   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   item_type              fq_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type              cls_item;
   logic                  push;
   logic                  pop;

   // Classify the incoming item
   always_comb begin
      cls_item.valve_index = req_valve_index;
      cls_item.command_on  = req_command_on;
      if (!req_func) begin
         cls_item.cls = CLS_TICK;
      end else if (valve_exists(req_valve_index, valve_present)) begin
         cls_item.cls = CLS_COMMAND;
      end else begin
         cls_item.cls = CLS_SKIP;
      end
   end

   assign req_ready  = (cnt_ff != FQ_CNT_W'(FQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = fq_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + FQ_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

>>> hdl/vsmb_back.sv
// ----------------------------------------------------------------------------
// Valve sequencer step engine
// Runs one input through the phase machine: queues commands, scans the
// pending queue, applies phase checks, drains commands and streams results.
// ----------------------------------------------------------------------------
`include "valve_sequencer_master_booster_core_macros.svh"

module vsmb_back
   import vsmb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               item_valid,
   output logic               item_ready,
   input  item_type           item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [VALVE_W-1:0] rsp_relay_index,
   output logic               rsp_relay_on,
   output logic [2:0]         rsp_phase,
   output logic [MASK_W-1:0]  rsp_open_mask,
   output logic               rsp_dropped,
   output logic               rsp_last
);

   localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int SW        = CW + 1;
   localparam int RES_DEPTH = QUEUE_DEPTH + 2;
   localparam int RW        = $clog2(RES_DEPTH);
   localparam int RCW       = $clog2(RES_DEPTH + 1);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   step_type               st_ff, st_in;
   phase_type              phase_ff, phase_in;
   logic [MASK_W-1:0]      open_ff, open_in;
   logic [ELAPSED_W-1:0]   ru_el_ff, ru_el_in;
   logic [ELAPSED_W-1:0]   bo_el_ff, bo_el_in;
   logic [ELAPSED_W-1:0]   rd_el_ff, rd_el_in;
   logic [QW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   has_on_ff, has_on_in;
   logic                   dropped_ff, dropped_in;
   logic [RCW-1:0]         res_cnt_ff, res_cnt_in;
   logic [RCW-1:0]         out_idx_ff, out_idx_in;

   pend_type               q_mem [QUEUE_DEPTH];
   pend_type               q_rd_ff;
   logic                   q_we, q_re;
   logic [QW-1:0]          q_waddr, q_raddr;
   pend_type               q_wdata;

   res_type                res_mem [RES_DEPTH];
   res_type                res_rd_ff;
   logic                   res_we, res_re;
   res_type                res_wdata;

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [VALVE_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                   rsp_on_ff, rsp_on_in;
   phase_type              rsp_phase_ff, rsp_phase_in;
   logic [MASK_W-1:0]      rsp_open_ff, rsp_open_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_free;

   phase_type              chk_phase;
   logic [ELAPSED_W-1:0]   chk_ru, chk_bo;
   logic                   chk_emit;
   res_type                chk_res;

   function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[QW-1:0];
   endfunction

   function automatic logic [ELAPSED_W-1:0] sat_inc(input logic [ELAPSED_W-1:0] v);
      return (v == ELAPSED_MAX) ? v : v + ELAPSED_W'(1);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Phase checks, in order; at most one relay write comes out of them
   always_comb begin
      phase_type            ph;
      logic [ELAPSED_W-1:0] ru;
      logic [ELAPSED_W-1:0] bo;
      ph       = phase_ff;
      ru       = ru_el_ff;
      bo       = bo_el_ff;
      chk_emit = 1'b0;
      chk_res  = '{kind: KIND_STATUS, relay_index: '0, relay_on: 1'b0};

      if (ph == PH_BOOST) begin
         if (has_on_ff) begin
            bo = '0;
         end else if (bo > ELAPSED_W'(cfg.booster_seconds)) begin
            if (cfg.booster_present) begin
               chk_emit = 1'b1;
               chk_res  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b0};
            end
            ph = PH_RUN;
         end
      end

      if (ph == PH_IDLE && has_on_ff) begin
         if (cfg.master_present) begin
            chk_emit = 1'b1;
            chk_res  = '{kind: KIND_MASTER, relay_index: '0, relay_on: 1'b1};
            ru       = '0;
            ph       = PH_RUN_UP;
         end else if (cfg.booster_present) begin
            chk_emit = 1'b1;
            chk_res  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b1};
            bo       = '0;
            ph       = PH_BOOST;
         end else begin
            ph = PH_RUN;
         end
      end

      if (ph == PH_RUN_UP && ru > ELAPSED_W'(cfg.run_up_seconds)) begin
         if (cfg.booster_present) begin
            chk_emit = 1'b1;
            chk_res  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b1};
            bo       = '0;
            ph       = PH_BOOST;
         end else begin
            ph = PH_RUN;
         end
      end

      if (ph == PH_RUN && has_on_ff && cfg.booster_present) begin
         chk_emit = 1'b1;
         chk_res  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b1};
         bo       = '0;
         ph       = PH_BOOST;
      end

      if (ph == PH_RUN_DOWN) begin
         if (has_on_ff) begin
            if (cfg.booster_present) begin
               chk_emit = 1'b1;
               chk_res  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b1};
               bo       = '0;
               ph       = PH_BOOST;
            end else begin
               ph = PH_RUN;
            end
         end else if (rd_el_ff > ELAPSED_W'(cfg.run_down_seconds)) begin
            if (cfg.master_present) begin
               chk_emit = 1'b1;
               chk_res  = '{kind: KIND_MASTER, relay_index: '0, relay_on: 1'b0};
            end
            ph = PH_IDLE;
         end
      end

      chk_phase = ph;
      chk_ru    = ru;
      chk_bo    = bo;
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == count_ff && !rd_vld_ff) begin
               st_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (chk_phase == PH_BOOST || chk_phase == PH_RUN) begin
               st_in = ST_DRAIN_RD;
            end else begin
               st_in = ST_EMIT_RD;
            end
         end
         ST_DRAIN_RD: begin
            st_in = (count_ff != '0) ? ST_DRAIN_EX : ST_FINISH;
         end
         ST_DRAIN_EX: begin
            st_in = ST_DRAIN_RD;
         end
         ST_FINISH: begin
            st_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            st_in = (out_idx_ff != res_cnt_ff) ? ST_EMIT_LD : ST_EMIT_ST;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               st_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_ST: begin
            if (out_free) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Datapath
   always_comb begin
      phase_in       = phase_ff;
      open_in        = open_ff;
      ru_el_in       = ru_el_ff;
      bo_el_in       = bo_el_ff;
      rd_el_in       = rd_el_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      rd_vld_in      = rd_vld_ff;
      has_on_in      = has_on_ff;
      dropped_in     = dropped_ff;
      res_cnt_in     = res_cnt_ff;
      out_idx_in     = out_idx_ff;
      q_we           = 1'b0;
      q_re           = 1'b0;
      q_waddr        = wrap_add(head_ff, count_ff);
      q_raddr        = head_ff;
      q_wdata        = '{valve_index: item.valve_index, command_on: item.command_on};
      res_we         = 1'b0;
      res_re         = 1'b0;
      res_wdata      = chk_res;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_on_in      = rsp_on_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_open_in    = rsp_open_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;

      case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               dropped_in = 1'b0;
               has_on_in  = 1'b0;
               scan_in    = '0;
               rd_vld_in  = 1'b0;
               case (item.cls)
                  CLS_TICK: begin
                     ru_el_in = sat_inc(ru_el_ff);
                     bo_el_in = sat_inc(bo_el_ff);
                     rd_el_in = sat_inc(rd_el_ff);
                  end
                  CLS_COMMAND: begin
                     if (count_ff != CW'(QUEUE_DEPTH)) begin
                        q_we     = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, check the entry read the cycle before
            rd_vld_in = 1'b0;
            if (scan_ff != count_ff) begin
               q_re      = 1'b1;
               q_raddr   = wrap_add(head_ff, scan_ff);
               scan_in   = scan_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && q_rd_ff.command_on && !open_ff[q_rd_ff.valve_index]) begin
               has_on_in = 1'b1;
            end
         end
         ST_PHASE: begin
            phase_in = chk_phase;
            ru_el_in = chk_ru;
            bo_el_in = chk_bo;
            if (chk_emit) begin
               res_we     = 1'b1;
               res_cnt_in = res_cnt_ff + RCW'(1);
            end
         end
         ST_DRAIN_RD: begin
            if (count_ff != '0) begin
               q_re = 1'b1;
            end
         end
         ST_DRAIN_EX: begin
            if (valve_exists(q_rd_ff.valve_index, cfg.valve_present) &&
                open_ff[q_rd_ff.valve_index] != q_rd_ff.command_on) begin
               open_in[q_rd_ff.valve_index] = q_rd_ff.command_on;
               res_we     = 1'b1;
               res_wdata  = '{kind: KIND_VALVE, relay_index: q_rd_ff.valve_index,
                              relay_on: q_rd_ff.command_on};
               res_cnt_in = res_cnt_ff + RCW'(1);
            end
            head_in  = wrap_add(head_ff, CW'(1));
            count_in = count_ff - CW'(1);
         end
         ST_FINISH: begin
            if (open_ff == '0) begin
               if (phase_ff == PH_BOOST && cfg.booster_present) begin
                  res_we     = 1'b1;
                  res_wdata  = '{kind: KIND_BOOSTER, relay_index: '0, relay_on: 1'b0};
                  res_cnt_in = res_cnt_ff + RCW'(1);
               end
               if (cfg.master_present) begin
                  phase_in = PH_RUN_DOWN;
                  rd_el_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            if (out_idx_ff != res_cnt_ff) begin
               res_re = 1'b1;
            end
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = res_rd_ff.kind;
               rsp_idx_in     = res_rd_ff.relay_index;
               rsp_on_in      = res_rd_ff.relay_on;
               rsp_phase_in   = phase_ff;
               rsp_open_in    = open_ff;
               rsp_dropped_in = 1'b0;
               rsp_last_in    = 1'b0;
               out_idx_in     = out_idx_ff + RCW'(1);
            end
         end
         ST_EMIT_ST: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_STATUS;
               rsp_idx_in     = '0;
               rsp_on_in      = 1'b0;
               rsp_phase_in   = phase_ff;
               rsp_open_in    = open_ff;
               rsp_dropped_in = dropped_ff;
               rsp_last_in    = 1'b1;
               res_cnt_in     = '0;
               out_idx_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs
   always_comb begin
      item_ready      = (st_ff == ST_IDLE);
      rsp_valid       = rsp_valid_ff;
      rsp_kind        = rsp_kind_ff;
      rsp_relay_index = rsp_idx_ff;
      rsp_relay_on    = rsp_on_ff;
      rsp_phase       = rsp_phase_ff;
      rsp_open_mask   = rsp_open_ff;
      rsp_dropped     = rsp_dropped_ff;
      rsp_last        = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         open_ff      <= '0;
         ru_el_ff     <= '0;
         bo_el_ff     <= '0;
         rd_el_ff     <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         has_on_ff    <= 1'b0;
         dropped_ff   <= 1'b0;
         res_cnt_ff   <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         open_ff      <= open_in;
         ru_el_ff     <= ru_el_in;
         bo_el_ff     <= bo_el_in;
         rd_el_ff     <= rd_el_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         has_on_ff    <= has_on_in;
         dropped_ff   <= dropped_in;
         res_cnt_ff   <= res_cnt_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_on_ff      <= rsp_on_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_open_ff    <= rsp_open_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Pending command queue
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      if (q_re) begin
         q_rd_ff <= q_mem[q_raddr];
      end
   end

   // Result buffer for one step
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_cnt_ff[RW-1:0]] <= res_wdata;
      end
      if (res_re) begin
         res_rd_ff <= res_mem[out_idx_ff[RW-1:0]];
      end
   end

   `VSMB_ASSERT_IMPLY(a_idle_buffer_empty, st_ff == ST_IDLE, res_cnt_ff == '0 && out_idx_ff == '0, "result buffer not empty between steps")
   `VSMB_ASSERT_IMPLY(a_flowing_has_open, st_ff == ST_IDLE && (phase_ff == PH_BOOST || phase_ff == PH_RUN), open_ff != '0 && count_ff == '0, "boost or run with no open valve or undrained queue")
   `VSMB_ASSERT_IMPLY(a_dropped_on_status, rsp_valid_ff && !rsp_last_ff, !rsp_dropped_ff, "drop flag on a non-status result")
   `VSMB_ASSERT_NEXT(a_status_reopens, st_ff == ST_EMIT_ST && out_free, st_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff, "status transfer did not close the step")

endmodule

>>> tb/vsmb_sequence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve sequencer result checker
// Watches the request, result and register channels of the valve sequencer.
// It keeps its own copy of the registers and the sequencing state and
// predicts the results of every request. Each result transfer is compared
// with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module vsmb_sequence_checker
   import vsmb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_func,
   input  logic [VALVE_W-1:0]     req_valve_index,
   input  logic                   req_command_on,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [1:0]             rsp_kind,
   input  logic [VALVE_W-1:0]     rsp_relay_index,
   input  logic                   rsp_relay_on,
   input  logic [2:0]             rsp_phase,
   input  logic [MASK_W-1:0]      rsp_open_mask,
   input  logic                   rsp_dropped,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_count,
   output int                     awaiting,
   output int                     items_in,
   output int                     results_out,
   output int                     drops_seen
);

   localparam int REPORT_LIMIT = 10;
   localparam logic [ELAPSED_W-1:0] ELAPSED_CEILING = '1;

   typedef struct packed {
      kind_type           kind;
      logic [VALVE_W-1:0] relay_index;
      logic               relay_on;
      phase_type          phase;
      logic [MASK_W-1:0]  open_mask;
      logic               dropped;
      logic               last;
   } relay_report_type;

   cfg_type              settings;
   phase_type            phase_q;
   logic [MASK_W-1:0]    open_q;
   logic                 master_q;
   logic                 booster_q;
   logic [ELAPSED_W-1:0] run_up_el;
   logic [ELAPSED_W-1:0] boost_el;
   logic [ELAPSED_W-1:0] run_down_el;
   pend_type             pending[$];
   relay_report_type     step_reports[$];
   relay_report_type     expected_reports[$];

   function automatic logic [ELAPSED_W-1:0] bump(input logic [ELAPSED_W-1:0] v);
      return (v == ELAPSED_CEILING) ? v : v + ELAPSED_W'(1);
   endfunction

   // All eight indexes are within the valve count; only the present bit matters.
   function automatic logic valve_fitted(input logic [VALVE_W-1:0] idx);
      return settings.valve_present[idx];
   endfunction

   task automatic note_result(input kind_type kind, input logic [VALVE_W-1:0] idx,
                              input logic on);
      relay_report_type r;
      r = '0;
      r.kind = kind;
      r.relay_index = idx;
      r.relay_on = on;
      step_reports.insert(step_reports.size(), r);
   endtask

   task automatic drive_booster(input logic on);
      if (settings.booster_present) begin
         booster_q = on;
         note_result(KIND_BOOSTER, '0, on);
      end
   endtask

   task automatic drive_master(input logic on);
      if (settings.master_present) begin
         master_q = on;
         note_result(KIND_MASTER, '0, on);
      end
   endtask

   task automatic start_boost_or_run();
      if (settings.booster_present) begin
         drive_booster(1'b1);
         boost_el = '0;
         phase_q = PH_BOOST;
      end else begin
         phase_q = PH_RUN;
      end
   endtask

   task automatic advance_sequencer(input logic func, input logic [VALVE_W-1:0] vidx,
                                    input logic von);
      logic             dropped;
      logic             has_on;
      pend_type         cmd;
      relay_report_type r;
      dropped = 1'b0;
      has_on = 1'b0;
      step_reports.delete();
      if (func) begin
         if (valve_fitted(vidx)) begin
            if (pending.size() < QUEUE_DEPTH) begin
               cmd.valve_index = vidx;
               cmd.command_on = von;
               pending.insert(pending.size(), cmd);
            end else begin
               dropped = 1'b1;
            end
         end
      end else begin
         run_up_el = bump(run_up_el);
         boost_el = bump(boost_el);
         run_down_el = bump(run_down_el);
      end
      // A queued opening of a closed valve counts even if the valve was removed.
      foreach (pending[i]) begin
         if (pending[i].command_on && !open_q[pending[i].valve_index])
            has_on = 1'b1;
      end
      if (phase_q == PH_BOOST) begin
         if (has_on) begin
            boost_el = '0;
         end else if (boost_el > settings.booster_seconds) begin
            drive_booster(1'b0);
            phase_q = PH_RUN;
         end
      end
      if (phase_q == PH_IDLE && has_on) begin
         if (settings.master_present) begin
            drive_master(1'b1);
            run_up_el = '0;
            phase_q = PH_RUN_UP;
         end else begin
            start_boost_or_run();
         end
      end
      if (phase_q == PH_RUN_UP && run_up_el > settings.run_up_seconds)
         start_boost_or_run();
      if (phase_q == PH_RUN && has_on && settings.booster_present)
         start_boost_or_run();
      if (phase_q == PH_RUN_DOWN) begin
         if (has_on) begin
            start_boost_or_run();
         end else if (run_down_el > settings.run_down_seconds) begin
            drive_master(1'b0);
            phase_q = PH_IDLE;
         end
      end
      if (phase_q == PH_BOOST || phase_q == PH_RUN) begin
         while (pending.size() > 0) begin
            cmd = pending.pop_front();
            if (valve_fitted(cmd.valve_index) &&
                open_q[cmd.valve_index] != cmd.command_on) begin
               open_q[cmd.valve_index] = cmd.command_on;
               note_result(KIND_VALVE, cmd.valve_index, cmd.command_on);
            end
         end
         if (open_q == '0) begin
            if (phase_q == PH_BOOST)
               drive_booster(1'b0);
            if (settings.master_present) begin
               phase_q = PH_RUN_DOWN;
               run_down_el = '0;
            end else begin
               phase_q = PH_IDLE;
            end
         end
      end
      note_result(KIND_STATUS, '0, 1'b0);
      foreach (step_reports[k]) begin
         r = step_reports[k];
         r.phase = phase_q;
         r.open_mask = open_q;
         if (k == step_reports.size() - 1) begin
            r.dropped = dropped;
            r.last = 1'b1;
         end
         expected_reports.insert(expected_reports.size(), r);
      end
   endtask

   always @(posedge clock) begin
      relay_report_type want;
      relay_report_type got;
      if (reset) begin
         settings = '0;
         settings.run_up_seconds = RUN_UP_SECONDS_RESET;
         settings.run_down_seconds = RUN_DOWN_SECONDS_RESET;
         phase_q = PH_IDLE;
         open_q = '0;
         master_q = 1'b0;
         booster_q = 1'b0;
         run_up_el = '0;
         boost_el = '0;
         run_down_el = '0;
         pending.delete();
         expected_reports.delete();
         mismatch_count = 0;
         items_in = 0;
         results_out = 0;
         drops_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind = kind_type'(rsp_kind);
            got.relay_index = rsp_relay_index;
            got.relay_on = rsp_relay_on;
            got.phase = phase_type'(rsp_phase);
            got.open_mask = rsp_open_mask;
            got.dropped = rsp_dropped;
            got.last = rsp_last;
            if (rsp_dropped)
               drops_seen++;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t result %0d with nothing expected: kind=%0d idx=%0d on=%0d",
                           $realtime, results_out, got.kind, got.relay_index,
                           got.relay_on);
            end else begin
               want = expected_reports.pop_front();
               if (got.kind !== want.kind || got.relay_index !== want.relay_index ||
                   got.relay_on !== want.relay_on || got.phase !== want.phase ||
                   got.open_mask !== want.open_mask || got.dropped !== want.dropped ||
                   got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t result %0d: expected kind=%0d idx=%0d on=%0d ",
                               "phase=%0d mask=%02h drop=%0d last=%0d, got kind=%0d ",
                               "idx=%0d on=%0d phase=%0d mask=%02h drop=%0d last=%0d"},
                              $realtime, results_out, want.kind, want.relay_index,
                              want.relay_on, want.phase, want.open_mask, want.dropped,
                              want.last, got.kind, got.relay_index, got.relay_on,
                              got.phase, got.open_mask, got.dropped, got.last);
               end
            end
            results_out++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MASTER_PRESENT:   settings.master_present = csr_data[0];
               CSR_BOOSTER_PRESENT:  settings.booster_present = csr_data[0];
               CSR_VALVE_PRESENT:    settings.valve_present = csr_data[MASK_W-1:0];
               CSR_BOOSTER_SECONDS:  settings.booster_seconds = csr_data;
               CSR_RUN_UP_SECONDS:   settings.run_up_seconds = csr_data;
               CSR_RUN_DOWN_SECONDS: settings.run_down_seconds = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_sequencer(req_func, req_valve_index, req_command_on);
            items_in++;
         end
      end
      awaiting = expected_reports.size();
   end

endmodule

>>> tb/tb_valve_sequencer_master_booster_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve sequencer testbench
// Drives ticks and valve commands into the sequencer under a series of
// register settings, with random gaps and stalls on both channels, a long
// result stall that backs up the input and a full drain pause. A checker
// beside the block predicts and compares every result; this module only
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_valve_sequencer_master_booster_core;
   import vsmb_pkg::*;

   localparam int    QUEUE_DEPTH      = 16;
   localparam int    CLOCK_PERIOD     = 8;
   localparam int    RESET_CYCLES     = 9;
   localparam int    SETTLE_CYCLES    = 8;
   localparam int    TAIL_CYCLES      = 200;
   localparam int    LONG_HOLD_CYCLES = 300;
   localparam longint LIMIT_CYCLES    = 1200000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [VALVE_W-1:0]     req_valve_index;
   logic                   req_command_on;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_kind;
   logic [VALVE_W-1:0]     rsp_relay_index;
   logic                   rsp_relay_on;
   logic [2:0]             rsp_phase;
   logic [MASK_W-1:0]      rsp_open_mask;
   logic                   rsp_dropped;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int      mismatch_count;
   int      awaiting;
   int      items_in;
   int      results_out;
   int      drops_seen;
   cfg_type programmed;
   bit      calm_mode = 1'b0;          // no idling on either side
   bit      long_hold_request = 1'b0;  // set here, cleared by the receiver

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   valve_sequencer_master_booster_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_valve_index(req_valve_index),
      .req_command_on (req_command_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_relay_index(rsp_relay_index),
      .rsp_relay_on   (rsp_relay_on),
      .rsp_phase      (rsp_phase),
      .rsp_open_mask  (rsp_open_mask),
      .rsp_dropped    (rsp_dropped),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   vsmb_sequence_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_valve_index(req_valve_index),
      .req_command_on (req_command_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_relay_index(rsp_relay_index),
      .rsp_relay_on   (rsp_relay_on),
      .rsp_phase      (rsp_phase),
      .rsp_open_mask  (rsp_open_mask),
      .rsp_dropped    (rsp_dropped),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting),
      .items_in       (items_in),
      .results_out    (results_out),
      .drops_seen     (drops_seen)
   );

   // Hard stop in case a handshake never completes.
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("valve_sequencer_master_booster_core: mismatch");
      $finish;
   end

   // Result receiver: random ready and stall bursts, one assignment per
   // falling edge. A long hold request overrides the next burst; calm mode
   // keeps ready high for the rest of the run.
   initial begin : receiver
      int   len;
      logic level;
      rsp_ready = 1'b0;
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            level = 1'b0;
            len = LONG_HOLD_CYCLES;
         end else if (calm_mode) begin
            level = 1'b1;
            len = 1;
         end else if ($urandom_range(0, 99) < 35) begin
            level = 1'b0;
            len = $urandom_range(1, 13);
         end else begin
            level = 1'b1;
            len = $urandom_range(1, 24);
         end
         repeat (len) begin
            @(negedge clock);
            rsp_ready <= level;
         end
      end
   end

   function automatic cfg_type make_settings(input logic m, input logic b,
                                             input logic [MASK_W-1:0] present,
                                             input logic [SECONDS_W-1:0] boost_s,
                                             input logic [SECONDS_W-1:0] run_up_s,
                                             input logic [SECONDS_W-1:0] run_down_s);
      cfg_type c;
      c.master_present = m;
      c.booster_present = b;
      c.valve_present = present;
      c.booster_seconds = boost_s;
      c.run_up_seconds = run_up_s;
      c.run_down_seconds = run_down_s;
      return c;
   endfunction

   // Drop valid, wait until every predicted result has come, then idle a bit.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaiting != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Write all six registers with the block idle.
   task automatic program_registers(input cfg_type c);
      settle();
      csr_write(CSR_MASTER_PRESENT, CSR_DATA_W'(c.master_present));
      csr_write(CSR_BOOSTER_PRESENT, CSR_DATA_W'(c.booster_present));
      csr_write(CSR_VALVE_PRESENT, CSR_DATA_W'(c.valve_present));
      csr_write(CSR_BOOSTER_SECONDS, c.booster_seconds);
      csr_write(CSR_RUN_UP_SECONDS, c.run_up_seconds);
      csr_write(CSR_RUN_DOWN_SECONDS, c.run_down_seconds);
      csr_valid <= 1'b0;
      programmed = c;
   endtask

   // Offer one request and hold it until the transfer; then maybe idle.
   task automatic offer_item(input logic func, input logic [VALVE_W-1:0] idx,
                             input logic on);
      req_valid <= 1'b1;
      req_func <= func;
      req_valve_index <= idx;
      req_command_on <= on;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (!calm_mode && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   // Mostly ticks and commands for fitted valves, some for absent ones.
   // Only requests the block acts on count toward the total.
   task automatic random_items(input int total, input int hold_at, input int pause_at);
      int                 counted;
      logic               func;
      logic [VALVE_W-1:0] idx;
      logic               on;
      counted = 0;
      while (counted < total) begin
         if (counted == hold_at) begin
            // Stall the results while the sender keeps offering requests.
            long_hold_request = 1'b1;
            hold_at = -1;
         end
         if (counted == pause_at) begin
            // Hold off the sender until everything has drained.
            req_valid <= 1'b0;
            while (awaiting != 0)
               @(negedge clock);
            @(negedge clock);
            pause_at = -1;
         end
         func = ($urandom_range(0, 99) >= 35);
         idx = VALVE_W'($urandom_range(0, VALVES - 1));
         on = ($urandom_range(0, 99) < 50);
         if (func && $urandom_range(0, 99) < 85) begin
            while (!programmed.valve_present[idx])
               idx = VALVE_W'($urandom_range(0, VALVES - 1));
         end
         offer_item(func, idx, on);
         if (!func || programmed.valve_present[idx])
            counted++;
      end
   endtask

   initial begin : stimulus
      logic [3:0] fill_order [17];
      // {valve, on}: opens and closes that fill the queue during run-up;
      // valve 7 is removed before the drain and the last one is dropped.
      fill_order = '{4'h1, 4'hF, 4'h3, 4'h2, 4'h5, 4'h4, 4'h7, 4'h6, 4'h9,
                     4'h8, 4'hB, 4'hA, 4'hD, 4'hC, 4'h0, 4'h1, 4'hB};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_valve_index = '0;
      req_command_on = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      programmed = make_settings(1'b0, 1'b0, '0, '0, RUN_UP_SECONDS_RESET,
                                 RUN_DOWN_SECONDS_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: a tick, and a command for a valve that is absent.
      offer_item(1'b0, '0, 1'b0);
      offer_item(1'b1, 3'd3, 1'b1);

      // Both relays, zero delays: the first opening starts run-up, the queue
      // fills behind it and the seventeenth command is dropped.
      program_registers(make_settings(1'b1, 1'b1, 8'hFF, 16'd0, 16'd0, 16'd0));
      foreach (fill_order[i])
         offer_item(1'b1, fill_order[i][3:1], fill_order[i][0]);

      // Remove valve 7 while its opening is queued, then tick through boost,
      // close the last valve and let the master run down.
      program_registers(make_settings(1'b1, 1'b1, 8'h7F, 16'd0, 16'd0, 16'd0));
      offer_item(1'b0, 3'd7, 1'b1);
      offer_item(1'b0, 3'd0, 1'b0);
      offer_item(1'b1, 3'd0, 1'b0);
      offer_item(1'b0, 3'd5, 1'b1);

      // No relays fitted: relay writes are skipped.
      program_registers(make_settings(1'b0, 1'b0, 8'hFF, 16'd0, 16'd0, 16'd0));
      offer_item(1'b1, 3'd2, 1'b1);
      offer_item(1'b1, 3'd2, 1'b0);

      // Random phases over a spread of settings.
      program_registers(make_settings(1'b1, 1'b1, 8'hFF, 16'd2, 16'd1, 16'd2));
      random_items(95, 40, -1);
      program_registers(make_settings(1'b0, 1'b1, MASK_W'($urandom_range(1, 255)),
                                      16'd0, 16'd0, 16'd0));
      random_items(80, -1, 45);
      program_registers(make_settings(1'b1, 1'b0, MASK_W'($urandom_range(1, 255)),
                                      16'd0, SECONDS_W'($urandom_range(0, 3)),
                                      SECONDS_W'($urandom_range(0, 3))));
      random_items(80, -1, -1);
      // Longest delays: run-up never ends and the queue overflows.
      program_registers(make_settings(1'b1, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      random_items(30, -1, -1);
      program_registers(make_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      MASK_W'($urandom_range(1, 255)),
                                      SECONDS_W'($urandom_range(0, 5)),
                                      SECONDS_W'($urandom_range(0, 5)),
                                      SECONDS_W'($urandom_range(0, 5))));
      random_items(70, -1, -1);
      // Last stretch at full rate on both sides.
      program_registers(make_settings(1'b1, 1'b1, MASK_W'($urandom_range(1, 255)),
                                      16'd1, 16'd0, 16'd1));
      calm_mode = 1'b1;
      random_items(80, -1, -1);

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Covered %0d request transfers and %0d result transfers (%0d with a drop),",
               items_in, results_out, drops_seen);
      $display("over ten register settings from absent relays to 65535-second delays.");
      if (awaiting != 0)
         $display("%0d expected results never arrived", awaiting);
      if (mismatch_count == 0 && awaiting == 0)
         $display("valve_sequencer_master_booster_core: match");
      else
         $display("valve_sequencer_master_booster_core: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/vsmb_pkg.sv
hdl/vsmb_front.sv
hdl/vsmb_back.sv
hdl/valve_sequencer_master_booster_core.sv
tb/vsmb_sequence_checker.sv
tb/tb_valve_sequencer_master_booster_core.sv
